/* rtl/gbn_pkg.sv */
// Shared types and constants of the Go-Back-N link layer.
package gbn_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int POS_W      = 16;
  localparam int SEQ_W      = 6;
  localparam int ENTRY_W    = SEQ_W + 8 + 8 + 32;
  localparam logic [SEQ_W-1:0] MAX_WINDOW = 6'd63;
  localparam int DIV_STEPS  = 16;

  typedef enum logic [1:0] {
    OP_APP  = 2'd0,
    OP_TICK = 2'd1,
    OP_ACK  = 2'd2,
    OP_DATA = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DELIV = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_DROP  = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_WINDOW  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_DIV0, ST_APP, ST_DROP, ST_TICK, ST_SEND,
    ST_SCAN, ST_CMP, ST_ACKAPP, ST_RX, ST_DELIV, ST_DIV3, ST_ACKOUT
  } state_t;

  typedef struct packed {
    logic  latch;
    logic  div_start;
    logic  ring_app;
    logic  tick_eval;
    logic  scan_init;
    logic  scan_rd;
    logic  scan_cmp;
    logic  ack_apply;
    logic  exp_wr;
    logic  out_load;
    kind_t out_sel;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic div_done;
    logic full;
    logic tick_send;
    logic scan_more;
    logic scan_hit;
    logic rx_match;
    logic out_free;
  } sts_t;

endpackage

/* rtl/gbn_ctrl.sv */
// Sequencing state machine of the Go-Back-N link layer.
module gbn_ctrl import gbn_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_accept,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_accept) state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        unique case (sts.op)
          OP_APP:  state_nxt = ST_DIV0;
          OP_TICK: state_nxt = ST_TICK;
          OP_ACK:  state_nxt = ST_SCAN;
          OP_DATA: state_nxt = ST_RX;
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_DIV0:   if (sts.div_done) state_nxt = ST_APP;
      ST_APP:    state_nxt = sts.full ? ST_DROP : ST_IDLE;
      ST_DROP:   if (sts.out_free) state_nxt = ST_IDLE;
      ST_TICK:   state_nxt = sts.tick_send ? ST_SEND : ST_IDLE;
      ST_SEND:   if (sts.out_free) state_nxt = ST_IDLE;
      ST_SCAN:   state_nxt = sts.scan_more ? ST_CMP : ST_ACKAPP;
      ST_CMP:    state_nxt = sts.scan_hit ? ST_ACKAPP : ST_SCAN;
      ST_ACKAPP: state_nxt = ST_IDLE;
      ST_RX:     state_nxt = sts.rx_match ? ST_DELIV : ST_ACKOUT;
      ST_DELIV:  if (sts.out_free) state_nxt = ST_DIV3;
      ST_DIV3:   if (sts.div_done) state_nxt = ST_ACKOUT;
      ST_ACKOUT: if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.out_sel = KIND_DATA;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:     cmd.latch = in_accept;
      ST_DISPATCH: begin
        cmd.div_start = (sts.op == OP_APP);
        cmd.scan_init = (sts.op == OP_ACK);
      end
      ST_APP:    cmd.ring_app = !sts.full;
      ST_DROP: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = KIND_DROP;
      end
      ST_TICK:   cmd.tick_eval = 1'b1;
      ST_SEND: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = KIND_DATA;
      end
      ST_SCAN:   cmd.scan_rd = sts.scan_more;
      ST_CMP:    cmd.scan_cmp = 1'b1;
      ST_ACKAPP: cmd.ack_apply = 1'b1;
      ST_DELIV: begin
        cmd.out_load  = sts.out_free;
        cmd.out_sel   = KIND_DELIV;
        cmd.div_start = sts.out_free;
      end
      ST_DIV3:   cmd.exp_wr = sts.div_done;
      ST_ACKOUT: begin
        cmd.out_load = sts.out_free;
        cmd.out_sel  = KIND_ACK;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/gbn_dp.sv */
// Datapath of the Go-Back-N link layer: window state, frame ring, divider and result register.
module gbn_dp import gbn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_fn,
  input  logic [7:0]  in_src,
  input  logic [7:0]  in_dst,
  input  logic [31:0] in_pay,
  input  logic [31:0] in_st,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_idx,
  input  logic [15:0] cfg_val,
  input  logic        out_take,
  output logic        out_valid,
  output kind_t       out_kind,
  output logic [5:0]  out_seq,
  output logic [7:0]  out_src,
  output logic [7:0]  out_dst,
  output logic [31:0] out_pay,
  output logic [31:0] out_stamp,
  output logic        out_last
);

  logic [ENTRY_W-1:0] ring [RING_DEPTH];

  op_t         op_r;
  logic [15:0] fn_r;
  logic [7:0]  src_r, dst_r;
  logic [31:0] pay_r, st_r;

  logic [POS_W-1:0] base_r, tail_r, limit_r;
  logic [6:0]       soff_r;
  logic [SEQ_W-1:0] exp_r;
  logic [15:0]      tcnt_r;
  logic             trun_r;
  logic [5:0]       wsize_r;
  logic [15:0]      tout_r;

  logic [6:0] k_r, found_r;
  logic [15:0] dq_r;
  logic [6:0]  drem_r;
  logic [4:0]  dcnt_r;
  logic [ENTRY_W-1:0] rd_r;
  logic        out_valid_r;

  logic [POS_W-1:0] lim, tl, tl1, nb, tl2, clip, effw16;
  logic [SEQ_W-1:0] effw;
  logic [15:0]      tcnt1;
  logic             expire, send;
  logic [6:0]       dvs, dstep, exp1;
  logic             rd_en;
  logic [RING_AW-1:0] rd_addr;

  assign lim    = limit_r - base_r;
  assign tl     = tail_r - base_r;
  assign tl1    = tl + 16'd1;
  assign effw   = (wsize_r < MAX_WINDOW) ? wsize_r : MAX_WINDOW;
  assign effw16 = {10'd0, effw};
  assign tcnt1  = tcnt_r + 16'd1;
  assign expire = trun_r && (tcnt1 >= tout_r);
  assign send   = !expire && ({9'd0, soff_r} < lim);
  assign nb     = base_r + {9'd0, found_r};
  assign tl2    = tail_r - nb;
  assign clip   = (effw16 < tl2) ? effw16 : tl2;
  assign dvs    = {1'b0, wsize_r} + 7'd1;
  assign dstep  = {drem_r[5:0], dq_r[15]};
  assign exp1   = {1'b0, exp_r} + 7'd1;

  // The ring is read either for the next frame to send or for the next ack candidate.
  assign rd_en   = (cmd.tick_eval && send) || cmd.scan_rd;
  assign rd_addr = cmd.scan_rd ? RING_AW'(base_r + {9'd0, k_r})
                               : RING_AW'(base_r + {9'd0, soff_r});

  always_ff @(posedge clk) begin
    if (cmd.ring_app) begin
      ring[tail_r[RING_AW-1:0]] <= {drem_r[5:0], src_r, dst_r, pay_r};
    end
    if (rd_en) begin
      rd_r <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= op_t'(in_op);
      fn_r  <= in_fn;
      src_r <= in_src;
      dst_r <= in_dst;
      pay_r <= in_pay;
      st_r  <= in_st;
    end
    if (cmd.div_start) begin
      dq_r   <= (op_r == OP_APP) ? fn_r : {9'd0, exp1};
      drem_r <= '0;
    end else if (dcnt_r != 5'd0) begin
      dq_r   <= {dq_r[14:0], 1'b0};
      drem_r <= (dstep >= dvs) ? (dstep - dvs) : dstep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0; tail_r <= '0; limit_r <= '0; soff_r <= '0;
      exp_r <= '0; tcnt_r <= '0; trun_r <= 1'b0;
      wsize_r <= 6'd7; tout_r <= 16'd10;
      k_r <= '0; found_r <= '0; dcnt_r <= '0; out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_WINDOW:  wsize_r <= cfg_val[5:0];
          CFG_TIMEOUT: tout_r  <= cfg_val;
          default: ;
        endcase
      end
      if (cmd.div_start) begin
        dcnt_r <= 5'(DIV_STEPS);
      end else if (dcnt_r != 5'd0) begin
        dcnt_r <= dcnt_r - 5'd1;
      end
      if (cmd.ring_app) begin
        tail_r <= tail_r + 16'd1;
        if (lim < tl1 && lim < effw16) limit_r <= limit_r + 16'd1;
      end
      if (cmd.tick_eval) begin
        if (expire) begin
          trun_r <= 1'b0; tcnt_r <= '0; soff_r <= '0;
        end else begin
          if (trun_r) tcnt_r <= tcnt1;
          if (send) begin
            soff_r <= soff_r + 7'd1;
            if (!trun_r) begin
              trun_r <= 1'b1; tcnt_r <= '0;
            end
          end
        end
      end
      if (cmd.scan_init) begin
        k_r <= 7'd1; found_r <= '0;
      end
      if (cmd.scan_cmp) begin
        if (sts.scan_hit) found_r <= k_r;
        else k_r <= k_r + 7'd1;
      end
      if (cmd.ack_apply) begin
        base_r  <= nb;
        limit_r <= nb + clip;
        soff_r  <= '0; trun_r <= 1'b0; tcnt_r <= '0;
      end
      if (cmd.exp_wr) exp_r <= drem_r[5:0];
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind <= cmd.out_sel;
      unique case (cmd.out_sel)
        KIND_DATA: begin
          out_seq <= rd_r[53:48]; out_src <= rd_r[47:40]; out_dst <= rd_r[39:32];
          out_pay <= rd_r[31:0]; out_stamp <= '0; out_last <= 1'b1;
        end
        KIND_DELIV: begin
          out_seq <= fn_r[5:0]; out_src <= src_r; out_dst <= dst_r;
          out_pay <= pay_r; out_stamp <= '0; out_last <= 1'b0;
        end
        KIND_ACK: begin
          out_seq <= exp_r; out_src <= dst_r; out_dst <= src_r;
          out_pay <= '0; out_stamp <= st_r; out_last <= 1'b1;
        end
        KIND_DROP: begin
          out_seq <= drem_r[5:0]; out_src <= src_r; out_dst <= dst_r;
          out_pay <= pay_r; out_stamp <= '0; out_last <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    sts.op        = op_r;
    sts.div_done  = (dcnt_r == 5'd0);
    sts.full      = (tl >= 16'(RING_DEPTH));
    sts.tick_send = send;
    sts.scan_more = ({9'd0, k_r} <= lim) && ({9'd0, k_r} < tl);
    sts.scan_hit  = ({10'd0, rd_r[53:48]} == fn_r);
    sts.rx_match  = (fn_r == {10'd0, exp_r});
    sts.out_free  = !out_valid_r || out_take;
  end

endmodule

/* rtl/go_back_n_link_layer.sv */
// Top level of the Go-Back-N link layer: controller and datapath.
//
//   Channel | Direction | Carries
//   in_     | request   | op in tuser, frame_number/addresses/payload/sent_time in tdata
//   out_    | result    | kind in tuser, seq/addresses/payload/stamp in tdata, last in tlast
//   cfg_    | write     | register index and data
//
// One request at a time; a full output register adds its wait. A send tick sends a frame only
// when one is due; an application frame passes a 16-step remainder unit and is dropped when the
// ring is full; a received data frame yields an ack, after a delivery and a pass of that unit
// when it is in sequence; an ack scans up to 63 ring entries, reading then comparing each, until one matches.
// Reset is synchronous; the ring itself is not cleared.
// A stalled result waits in the output register while the next request is taken.
module go_back_n_link_layer import gbn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,  // frame_number, source_address, dest_address, payload, sent_time
  input  logic [1:0]  in_tuser,  // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata, // seq_number, out_source, out_dest, out_payload, stamp, pad
  output logic [1:0]  out_tuser, // kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t  cmd;
  sts_t  sts;
  logic  busy, in_accept;
  kind_t kind;
  logic [5:0]  seq;
  logic [7:0]  osrc, odst;
  logic [31:0] opay, ostamp;

  assign in_tready = !busy;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk, .rst_n, .in_accept, .sts, .busy, .cmd
  );

  gbn_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_op(in_tuser), .in_fn(in_tdata[15:0]), .in_src(in_tdata[23:16]),
    .in_dst(in_tdata[31:24]), .in_pay(in_tdata[63:32]), .in_st(in_tdata[95:64]),
    .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_idx_t'(cfg_index)), .cfg_val(cfg_data),
    .out_take(out_tready), .out_valid(out_tvalid), .out_kind(kind), .out_seq(seq),
    .out_src(osrc), .out_dst(odst), .out_pay(opay), .out_stamp(ostamp),
    .out_last(out_tlast)
  );

  assign out_tuser = kind;
  assign out_tdata = {2'b00, ostamp, opay, odst, osrc, seq};

endmodule

/* rtl/gbn_checker.sv */
// Port-level checks of the Go-Back-N link layer and their binding.
module gbn_checker import gbn_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_deliv_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DELIV |-> !out_tlast)
    else $error("delivery marked as final result");

  a_ack_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ACK |-> out_tdata[53:22] == 32'd0 && out_tlast)
    else $error("ack carries a payload");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind go_back_n_link_layer gbn_checker u_gbn_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
);
